/* src/gcq_pkg.sv */
// shared types, constants and codes for the grouped class queue
`timescale 1ns / 1ps
`default_nettype none
package gcq_pkg;

  localparam int NUM_CLASSES = 10;
  localparam int ID_SPACE    = 4096;
  localparam int CLASS_DEPTH = 64;

  localparam int ID_W    = 12;
  localparam int CLS_W   = 4;
  localparam int MODE_W  = 2;
  localparam int STAT_W  = 2;

  localparam int ID_AW   = $clog2(ID_SPACE);
  localparam int SLOT_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int OPTR_W  = SLOT_W;
  localparam int OCNT_W  = $clog2(NUM_CLASSES + 1);
  localparam int PTR_W   = $clog2(CLASS_DEPTH);
  localparam int CNT_W   = $clog2(CLASS_DEPTH + 1);
  localparam int ITEM_N  = NUM_CLASSES * CLASS_DEPTH;
  localparam int ITEM_AW = $clog2(ITEM_N);

  localparam logic [MODE_W-1:0] MODE_ASSIGN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ENQ    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DEQ    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NOP    = 2'd3;

  localparam logic [STAT_W-1:0] ST_SERVED   = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] ST_UNMAPPED = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   item_id;
    logic [CLS_W-1:0]  class_id;
  } in_t;

  typedef struct packed {
    logic [ID_W-1:0]   served_id;
    logic [STAT_W-1:0] status;
  } out_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic clr_wr;
    logic take;
    logic fire;
  } ctl_t;

  typedef struct packed {
    logic clr_last;
    logic res_pend;
    logic out_free;
  } dps_t;

endpackage
`default_nettype wire

/* src/gcq_ctrl.sv */
// controller state machine: table clear, accept and execute sequencing
`timescale 1ns / 1ps
`default_nettype none
module gcq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  gcq_pkg::dps_t   dps,
  output gcq_pkg::ctl_t   ctl,
  output gcq_pkg::state_t state
);
  import gcq_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (dps.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (!dps.res_pend || dps.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    ctl.clr_wr = 1'b0;
    ctl.take   = 1'b0;
    ctl.fire   = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        ctl.clr_wr = 1'b1;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        ctl.take = in_valid;
      end
      S_EXEC: begin
        ctl.fire = !dps.res_pend || dps.out_free;
      end
      default: ;
    endcase
  end

  assign state = state_r;

endmodule
`default_nettype wire

/* src/gcq_dp.sv */
// datapath: class table, order queue, class fifos and result register
`timescale 1ns / 1ps
`default_nettype none
module gcq_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  gcq_pkg::ctl_t ctl,
  output gcq_pkg::dps_t dps,
  input  gcq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output gcq_pkg::out_t out_data
);
  import gcq_pkg::*;

  function automatic logic [ITEM_AW-1:0] item_addr(input logic [SLOT_W-1:0] s,
                                                   input logic [PTR_W-1:0]  p);
    item_addr = ITEM_AW'(32'(s) * CLASS_DEPTH + 32'(p));
  endfunction

  in_t                 req_r;
  logic [ID_AW-1:0]    clr_cnt_r;
  logic [CLS_W-1:0]    class_mem [ID_SPACE];
  logic [CLS_W-1:0]    class_rd_r;
  logic [ID_W-1:0]     item_mem [ITEM_N];
  logic [ID_W-1:0]     item_rd_r;
  logic [CLS_W-1:0]    order_mem_r [NUM_CLASSES];
  logic [CLS_W-1:0]    order_mem_nxt [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] active_r, active_nxt;
  logic [OPTR_W-1:0]   order_head_r, order_head_nxt;
  logic [OCNT_W-1:0]   order_count_r, order_count_nxt;
  logic [PTR_W-1:0]    fifo_head_r [NUM_CLASSES];
  logic [PTR_W-1:0]    fifo_head_nxt [NUM_CLASSES];
  logic [CNT_W-1:0]    fifo_count_r [NUM_CLASSES];
  logic [CNT_W-1:0]    fifo_count_nxt [NUM_CLASSES];
  logic                out_valid_r;
  out_t                out_data_r;

  logic                cm_we, cm_re;
  logic [ID_AW-1:0]    cm_addr;
  logic [CLS_W-1:0]    cm_wdata;
  logic                in_range, cls_ok;

  logic [CLS_W-1:0]    head_cls;
  logic [SLOT_W-1:0]   head_slot, enq_slot, sel_slot, rd_slot;
  logic                head_ok, enq_ok;
  logic [PTR_W-1:0]    sel_head;
  logic [CNT_W-1:0]    sel_cnt;
  logic [PTR_W:0]      ptr_sum;
  logic [PTR_W-1:0]    tail_ptr;
  logic [OCNT_W:0]     ord_sum;
  logic [OPTR_W-1:0]   order_tail;
  logic                item_we;
  logic [ITEM_AW-1:0]  item_waddr;
  logic                res_pend;
  out_t                res;

  // class table with clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (ctl.clr_wr) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  assign in_range = 32'(in_data.item_id) < ID_SPACE;
  assign cls_ok   = 32'(in_data.class_id) <= NUM_CLASSES;
  assign cm_we    = ctl.clr_wr ||
                    (ctl.take && in_data.mode == MODE_ASSIGN && in_range && cls_ok);
  assign cm_re    = ctl.take && in_data.mode == MODE_ENQ;
  assign cm_addr  = ctl.clr_wr ? clr_cnt_r : ID_AW'(in_data.item_id);
  assign cm_wdata = ctl.clr_wr ? '0 : in_data.class_id;

  always_ff @(posedge clk) begin
    if (cm_we) class_mem[cm_addr] <= cm_wdata;
    if (cm_re) class_rd_r <= class_mem[cm_addr];
  end

  // head of order queue and selected class
  assign head_cls  = order_mem_r[order_head_r];
  assign head_slot = SLOT_W'(head_cls - 1'b1);
  assign enq_slot  = SLOT_W'(class_rd_r - 1'b1);
  assign enq_ok    = (32'(req_r.item_id) < ID_SPACE) && class_rd_r != '0 &&
                     32'(class_rd_r) <= NUM_CLASSES;
  assign sel_slot  = (req_r.mode == MODE_DEQ) ? head_slot : enq_slot;
  assign rd_slot   = ctl.take ? head_slot : sel_slot;
  assign sel_head  = fifo_head_r[rd_slot];
  assign sel_cnt   = fifo_count_r[rd_slot];
  assign head_ok   = head_cls != '0 && 32'(head_cls) <= NUM_CLASSES && sel_cnt != '0;

  assign ptr_sum  = {1'b0, sel_head} + (PTR_W + 1)'(sel_cnt);
  assign tail_ptr = (32'(ptr_sum) >= CLASS_DEPTH) ?
                    PTR_W'(32'(ptr_sum) - CLASS_DEPTH) : PTR_W'(ptr_sum);
  assign ord_sum    = (OCNT_W + 1)'(order_head_r) + (OCNT_W + 1)'(order_count_r);
  assign order_tail = (32'(ord_sum) >= NUM_CLASSES) ?
                      OPTR_W'(32'(ord_sum) - NUM_CLASSES) : OPTR_W'(ord_sum);

  always_ff @(posedge clk) begin
    if (ctl.take) req_r <= in_data;
  end

  // item store: read for dequeue at accept, written by enqueue
  assign item_waddr = item_addr(sel_slot, tail_ptr);

  always_ff @(posedge clk) begin
    if (item_we) item_mem[item_waddr] <= req_r.item_id;
    if (ctl.take && in_data.mode == MODE_DEQ) begin
      item_rd_r <= item_mem[item_addr(head_slot, sel_head)];
    end
  end

  // result of the request in execute
  always_comb begin
    res_pend = 1'b0;
    res      = '0;
    unique case (req_r.mode)
      MODE_ENQ: begin
        if (!enq_ok) begin
          res_pend      = 1'b1;
          res.served_id = req_r.item_id;
          res.status    = ST_UNMAPPED;
        end else if (32'(sel_cnt) >= CLASS_DEPTH) begin
          res_pend      = 1'b1;
          res.served_id = req_r.item_id;
          res.status    = ST_FULL;
        end
      end
      MODE_DEQ: begin
        res_pend = 1'b1;
        if (order_count_r != '0 && head_ok) begin
          res.served_id = item_rd_r;
          res.status    = ST_SERVED;
        end else begin
          res.status = ST_EMPTY;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    order_mem_nxt   = order_mem_r;
    active_nxt      = active_r;
    order_head_nxt  = order_head_r;
    order_count_nxt = order_count_r;
    fifo_head_nxt   = fifo_head_r;
    fifo_count_nxt  = fifo_count_r;
    item_we         = 1'b0;
    unique case (req_r.mode)
      MODE_ENQ: begin
        if (enq_ok && 32'(sel_cnt) < CLASS_DEPTH && ctl.fire) begin
          if (!active_r[sel_slot]) begin
            if (32'(order_count_r) < NUM_CLASSES) begin
              order_mem_nxt[order_tail] = class_rd_r;
              order_count_nxt           = order_count_r + 1'b1;
            end
            active_nxt[sel_slot] = 1'b1;
          end
          item_we                  = 1'b1;
          fifo_count_nxt[sel_slot] = sel_cnt + 1'b1;
        end
      end
      MODE_DEQ: begin
        if (order_count_r != '0 && ctl.fire) begin
          if (head_ok) begin
            fifo_head_nxt[sel_slot] = (32'(sel_head) == CLASS_DEPTH - 1) ?
                                      '0 : sel_head + 1'b1;
            fifo_count_nxt[sel_slot] = sel_cnt - 1'b1;
          end
          if (!head_ok || sel_cnt == CNT_W'(1)) begin
            if (head_ok) active_nxt[sel_slot] = 1'b0;
            order_head_nxt  = (32'(order_head_r) == NUM_CLASSES - 1) ?
                              '0 : order_head_r + 1'b1;
            order_count_nxt = order_count_r - 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r      <= '0;
      order_head_r  <= '0;
      order_count_r <= '0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        fifo_head_r[i]  <= '0;
        fifo_count_r[i] <= '0;
      end
    end else if (ctl.fire) begin
      active_r      <= active_nxt;
      order_head_r  <= order_head_nxt;
      order_count_r <= order_count_nxt;
      fifo_head_r   <= fifo_head_nxt;
      fifo_count_r  <= fifo_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fire) order_mem_r <= order_mem_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.fire && res_pend) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fire && res_pend) out_data_r <= res;
  end

  assign dps.clr_last = 32'(clr_cnt_r) == ID_SPACE - 1;
  assign dps.res_pend = res_pend;
  assign dps.out_free = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

endmodule
`default_nettype wire

/* src/grouped_class_queue.sv */
// grouped class queue top level: team queue engine
// execute: an accepted item moves from S_IDLE to S_EXEC, where any result is registered
// a new item is taken only once the last has executed: a lookup on the class
//   table and item memory, then an update held while the result register is full
// reset: synchronous; the class table is then cleared one entry a cycle, all
//   4096 entries, with in_stall high, before the first item is taken
`timescale 1ns / 1ps
`default_nettype none
module grouped_class_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  gcq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output gcq_pkg::out_t out_data
);
  import gcq_pkg::*;

  ctl_t   ctl;
  dps_t   dps;
  state_t state;

  gcq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .dps      (dps),
    .ctl      (ctl),
    .state    (state)
  );

  gcq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .dps       (dps),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state == S_EXEC))
    else $error("accepted beat not followed by execute");

  a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state == S_CLEAR) |-> in_stall)
    else $error("input taken during table clear");

  a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.fire && dps.res_pend) |=> out_valid)
    else $error("result lost after execute");
`endif

endmodule
`default_nettype wire

/* test/grouped_class_queue_test.sv */
// testbench for the grouped class queue: random and directed team queue traffic
`timescale 1ns / 1ps
module grouped_class_queue_test;
  import gcq_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int TAIL_BEATS  = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  in_t pending_beats [$];
  out_t expected_results [$];

  // team queue state as the block should hold it
  logic [CLS_W-1:0] id_class [ID_SPACE];
  logic [ID_W-1:0] class_fifo [NUM_CLASSES][$];
  int class_order [$];

  int in_gap = 0;
  int out_gap = 0;
  int results_seen = 0;
  int errors = 0;
  int cycle_count = 0;

  grouped_class_queue DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #1 clk = ~clk;

  task automatic predict_beat(input in_t b);
    int slot;
    out_t r;
    case (b.mode)
      MODE_ASSIGN: begin
        if (b.class_id <= NUM_CLASSES) id_class[b.item_id] = b.class_id;
      end
      MODE_ENQ: begin
        if (id_class[b.item_id] == '0) begin
          r = '{served_id: b.item_id, status: ST_UNMAPPED};
          expected_results.push_back(r);
        end else begin
          slot = int'(id_class[b.item_id]) - 1;
          if (class_fifo[slot].size() >= CLASS_DEPTH) begin
            r = '{served_id: b.item_id, status: ST_FULL};
            expected_results.push_back(r);
          end else begin
            if (class_fifo[slot].size() == 0) class_order.push_back(slot);
            class_fifo[slot].push_back(b.item_id);
          end
        end
      end
      MODE_DEQ: begin
        if (class_order.size() == 0) begin
          r = '{served_id: '0, status: ST_EMPTY};
        end else begin
          slot = class_order[0];
          r = '{served_id: class_fifo[slot].pop_front(), status: ST_SERVED};
          if (class_fifo[slot].size() == 0) void'(class_order.pop_front());
        end
        expected_results.push_back(r);
      end
      default: ;
    endcase
  endtask

  task automatic add_beat(input logic [MODE_W-1:0] mode, input int id, input int cls);
    in_t b;
    b.mode = mode;
    b.item_id = ID_W'(id);
    b.class_id = CLS_W'(cls);
    pending_beats.push_back(b);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_beat(in_data);
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_valid <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (pending_beats.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_beats.size() > TAIL_BEATS && (pending_beats.size() % 128) < 90
                     && $urandom_range(0, 5) == 0) begin
          in_valid <= 1'b0;
          in_gap <= $urandom_range(0, 4);
        end else begin
          in_data <= pending_beats.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // result monitor and stall source
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          $error("unexpected result beat: served_id %0d status %0d",
                 out_data.served_id, out_data.status);
          errors = errors + 1;
        end else begin
          out_t want;
          want = expected_results.pop_front();
          if (out_data.served_id !== want.served_id) begin
            $error("served_id: expected %0d, got %0d", want.served_id, out_data.served_id);
            errors = errors + 1;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            errors = errors + 1;
          end
        end
      end
      if (out_gap > 0) begin
        out_stall <= 1'b1;
        out_gap <= out_gap - 1;
      end else if (pending_beats.size() > TAIL_BEATS && (results_seen % 100) < 70
                   && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        out_gap <= $urandom_range(0, 4);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int pool [24];
    int r;
    int flood_id;
    int flood_cls;
    foreach (id_class[i]) id_class[i] = '0;

    // directed part
    add_beat(MODE_DEQ, 0, 0);
    add_beat(MODE_ENQ, 0, 0);
    add_beat(MODE_ASSIGN, 4095, 10);
    add_beat(MODE_ASSIGN, 0, 1);
    add_beat(MODE_ASSIGN, 5, 11);
    add_beat(MODE_ASSIGN, 6, 15);
    add_beat(MODE_ENQ, 4095, 15);
    add_beat(MODE_ENQ, 0, 0);
    add_beat(MODE_ENQ, 5, 0);
    add_beat(MODE_ENQ, 6, 0);
    add_beat(MODE_ENQ, 4095, 0);
    add_beat(MODE_NOP, 4095, 15);
    add_beat(MODE_DEQ, 4095, 15);
    add_beat(MODE_ENQ, 0, 0);
    add_beat(MODE_DEQ, 0, 0);
    add_beat(MODE_DEQ, 0, 0);
    add_beat(MODE_DEQ, 0, 0);
    add_beat(MODE_DEQ, 0, 0);
    add_beat(MODE_ASSIGN, 0, 0);
    add_beat(MODE_ENQ, 0, 0);
    add_beat(MODE_ASSIGN, 12'hAAA, 5);
    add_beat(MODE_ASSIGN, 12'h555, 10);
    add_beat(MODE_ENQ, 12'hAAA, 0);
    add_beat(MODE_ENQ, 12'h555, 0);
    add_beat(MODE_DEQ, 0, 0);
    add_beat(MODE_DEQ, 0, 0);

    // random part: a working set of mapped ids, with two floods of one class
    foreach (pool[i]) begin
      pool[i] = $urandom_range(0, ID_SPACE - 1);
      add_beat(MODE_ASSIGN, pool[i], $urandom_range(1, NUM_CLASSES));
    end
    for (int n = 0; n < 400; n++) begin
      if (n == 150 || n == 330) begin
        flood_id = $urandom_range(0, ID_SPACE - 1);
        flood_cls = $urandom_range(1, NUM_CLASSES);
        add_beat(MODE_ASSIGN, flood_id, flood_cls);
        repeat (CLASS_DEPTH + 2) add_beat(MODE_ENQ, flood_id, $urandom_range(0, 15));
      end
      r = $urandom_range(0, 99);
      if (r < 10) begin
        if ($urandom_range(0, 7) == 0)
          add_beat(MODE_ASSIGN, pool[$urandom_range(0, 23)], $urandom_range(11, 15));
        else
          add_beat(MODE_ASSIGN, pool[$urandom_range(0, 23)], $urandom_range(0, NUM_CLASSES));
      end else if (r < 55) begin
        add_beat(MODE_ENQ, pool[$urandom_range(0, 23)], $urandom_range(0, 15));
      end else if (r < 95) begin
        add_beat(MODE_DEQ, $urandom_range(0, ID_SPACE - 1), $urandom_range(0, 15));
      end else if (r < 97) begin
        add_beat(MODE_NOP, $urandom_range(0, ID_SPACE - 1), $urandom_range(0, 15));
      end else begin
        add_beat(MODE_ENQ, $urandom_range(0, ID_SPACE - 1), $urandom_range(0, 15));
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
